// ----- src/peak_meter_db_ballistics_assert.svh -----
// ----------------------------------------------------------------------------
// Peak meter assertion macros
// Shared concurrent assertion forms for the peak meter checkers.
// ----------------------------------------------------------------------------
`ifndef PEAK_METER_DB_BALLISTICS_ASSERT_SVH
`define PEAK_METER_DB_BALLISTICS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PMDB_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pmdb: same-cycle check failed");

// next-cycle implication, disabled in reset
`define PMDB_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pmdb: next-cycle check failed");

`endif

// ----- src/pmdb_pkg.sv -----
// ----------------------------------------------------------------------------
// pmdb_pkg
// Widths, constants and shared types of the peak meter.
// ----------------------------------------------------------------------------
package pmdb_pkg;

    localparam int PEAK_W       = 32;
    localparam int LEVEL_W      = 11;
    localparam int DISP_W       = 14;
    localparam int BAR_W        = 10;
    localparam int CHAN_W       = 2;
    localparam int DECAY_W      = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int EXP_W        = 5;
    localparam int FRAC_W       = 16;
    localparam int LOG_W        = EXP_W + FRAC_W;
    localparam int SUBMIT_LANES = 4;
    localparam int Q_DEPTH      = 2;

    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 2'd1;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 14'd240;
    localparam logic [PEAK_W-1:0]  FLOOR_RESET = 32'd256;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -11'sd600;
    localparam logic [11:0] LEVEL_SPAN = 12'd600;

    localparam logic [EXP_W-1:0] FULL_SCALE_EXP = 5'd31;
    // 200*log10(2) in Q16
    localparam logic [21:0] DB_SCALE_Q16 = 22'd3945660;
    // 50 * ceil(2^17/3): (t*50)/3 in one product
    localparam logic [21:0] TARGET_MUL   = 22'd2184550;
    // ceil(2^19/10)
    localparam logic [15:0] BAR_MUL      = 16'd52429;

    typedef struct packed {
        logic full;
        logic empty;
    } pmdb_q_status_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [EXP_W-1:0]  exp;
        logic [FRAC_W-1:0] frac;
    } pmdb_log_res_t;

endpackage

// ----- src/peak_meter_db_ballistics.sv -----
// ----------------------------------------------------------------------------
// peak_meter_db_ballistics
// Multi-channel peak meter with dB conversion and falling display bars.
// ----------------------------------------------------------------------------
// Item channel (item_valid/item_stall): action 0 submits four peaks, which
// are folded into registered per-channel pending maxima; action 1 is a
// tick that snapshots and clears the pending peaks and queues the snapshot
// (two ticks deep). item_stall rises only while that queue is full.
// Result channel (result_valid/result_stall): each tick yields one result
// per channel in channel order, last marking the final one. A registered
// output stage holds a result while result_stall is high; the next channel
// waits for it.
// Per channel, a peak below the noise floor skips the log2 unit; otherwise
// the channel waits for the sixteen squarings of the shared log2 unit's
// single 32x32 multiplier. Submits are accepted while item_stall is low.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 decay_step,
// index 1 noise_floor; other indexes are ignored. Write only when idle.
// Reset clears pending peaks, display levels, the queue and the output
// stage, and restores decay_step 240 and noise_floor 256.
// ----------------------------------------------------------------------------
module peak_meter_db_ballistics #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                action,
    input  logic [pmdb_pkg::PEAK_W-1:0]         peak_in_one,
    input  logic [pmdb_pkg::PEAK_W-1:0]         peak_in_two,
    input  logic [pmdb_pkg::PEAK_W-1:0]         peak_out_one,
    input  logic [pmdb_pkg::PEAK_W-1:0]         peak_out_two,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [pmdb_pkg::CHAN_W-1:0]         channel,
    output logic [pmdb_pkg::BAR_W-1:0]          bar_level,
    output logic signed [pmdb_pkg::LEVEL_W-1:0] level_tenths_db,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmdb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pmdb_pkg::*;

    logic [DECAY_W-1:0] decay_step_reg, decay_step_next;
    logic [PEAK_W-1:0]  noise_floor_reg, noise_floor_next;

    logic [SUBMIT_LANES-1:0][PEAK_W-1:0] submit_peaks;
    logic [NUM_CHANNELS-1:0][PEAK_W-1:0] push_data;
    logic [NUM_CHANNELS-1:0][PEAK_W-1:0] head_data;
    logic                                push;
    logic                                pop;
    pmdb_q_status_t                      q_status;
    logic                                log_start;
    logic [PEAK_W-1:0]                   log_peak;
    pmdb_log_res_t                       log_res;

    assign submit_peaks[0] = peak_in_one;
    assign submit_peaks[1] = peak_in_two;
    assign submit_peaks[2] = peak_out_one;
    assign submit_peaks[3] = peak_out_two;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        decay_step_next  = decay_step_reg;
        noise_floor_next = noise_floor_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DECAY_STEP:  decay_step_next  = cfg_data[DECAY_W-1:0];
                REG_NOISE_FLOOR: noise_floor_next = cfg_data[PEAK_W-1:0];
                default:
                begin
                    decay_step_next = decay_step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_step_reg  <= DECAY_RESET;
            noise_floor_reg <= FLOOR_RESET;
        end
        else
        begin
            decay_step_reg  <= decay_step_next;
            noise_floor_reg <= noise_floor_next;
        end
    end

    pmdb_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .submit_peaks (submit_peaks),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    pmdb_queue #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    pmdb_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .peak  (log_peak),
        .res   (log_res)
    );

    pmdb_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .head_data       (head_data),
        .pop             (pop),
        .decay_step      (decay_step_reg),
        .noise_floor     (noise_floor_reg),
        .log_start       (log_start),
        .log_peak        (log_peak),
        .log_res         (log_res),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .channel         (channel),
        .bar_level       (bar_level),
        .level_tenths_db (level_tenths_db),
        .last            (last)
    );

endmodule

// ----- src/pmdb_front.sv -----
// ----------------------------------------------------------------------------
// pmdb_front
// Accepts items, folds submitted peaks into pending maxima and hands a
// snapshot of them to the queue on each tick.
// ----------------------------------------------------------------------------
module pmdb_front #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   item_valid,
    output logic                                                   item_stall,
    input  logic                                                   action,
    input  logic [pmdb_pkg::SUBMIT_LANES-1:0][pmdb_pkg::PEAK_W-1:0] submit_peaks,
    input  pmdb_pkg::pmdb_q_status_t                               q_status,
    output logic                                                   push,
    output logic [NUM_CHANNELS-1:0][pmdb_pkg::PEAK_W-1:0]          push_data
);
    import pmdb_pkg::*;

    logic [PEAK_W-1:0] pending_reg  [NUM_CHANNELS];
    logic [PEAK_W-1:0] pending_next [NUM_CHANNELS];
    logic [PEAK_W-1:0] lane_peak    [NUM_CHANNELS];
    logic              accept;
    logic              tick;
    logic              submit;

    // channels past the submit lanes never see data
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        if (g < SUBMIT_LANES) begin : g_fed
            assign lane_peak[g] = submit_peaks[g];
        end
        else begin : g_unfed
            assign lane_peak[g] = '0;
        end
    end

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign tick       = accept && (action == ACT_TICK);
    assign submit     = accept && (action == ACT_SUBMIT);
    assign push       = tick;

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            push_data[i]    = pending_reg[i];
            pending_next[i] = pending_reg[i];
            if (tick)
            begin
                pending_next[i] = '0;
            end
            else if (submit && (lane_peak[i] > pending_reg[i]))
            begin
                pending_next[i] = lane_peak[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pending_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pending_reg[i] <= pending_next[i];
            end
        end
    end

endmodule

// ----- src/pmdb_queue.sv -----
// ----------------------------------------------------------------------------
// pmdb_queue
// Two-entry queue of tick snapshots between front and back.
// ----------------------------------------------------------------------------
module pmdb_queue #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          push,
    input  logic [NUM_CHANNELS-1:0][pmdb_pkg::PEAK_W-1:0] push_data,
    input  logic                                          pop,
    output logic [NUM_CHANNELS-1:0][pmdb_pkg::PEAK_W-1:0] head_data,
    output pmdb_pkg::pmdb_q_status_t                      status
);
    import pmdb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [NUM_CHANNELS-1:0][PEAK_W-1:0] entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_data    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/pmdb_log2.sv -----
// ----------------------------------------------------------------------------
// pmdb_log2
// Iterative log2 in Q16: five normalising steps, then sixteen squarings on
// one multiplier, one fraction bit per squaring.
// ----------------------------------------------------------------------------
module pmdb_log2 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pmdb_pkg::PEAK_W-1:0] peak,
    output pmdb_pkg::pmdb_log_res_t     res
);
    import pmdb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [31:0]       x_reg, x_next;
    logic [EXP_W-1:0]  e_reg, e_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [63:0]       sq;
    logic [32:0]       sq_q31;

    assign sq     = x_reg * x_reg;
    assign sq_q31 = sq[63:31];

    assign res.busy = (state_reg != ST_IDLE);
    assign res.done = done_reg;
    assign res.exp  = e_reg;
    assign res.frac = frac_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        e_next     = e_reg;
        frac_next  = frac_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = peak;
                    e_next     = FULL_SCALE_EXP;
                    frac_next  = '0;
                    cnt_next   = 4'd4;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // binary search for the leading one, widest step first
                case (cnt_reg)
                    4'd4:
                    begin
                        if (x_reg[31:16] == '0)
                        begin
                            x_next = {x_reg[15:0], 16'd0};
                            e_next = e_reg - 5'd16;
                        end
                    end
                    4'd3:
                    begin
                        if (x_reg[31:24] == '0)
                        begin
                            x_next = {x_reg[23:0], 8'd0};
                            e_next = e_reg - 5'd8;
                        end
                    end
                    4'd2:
                    begin
                        if (x_reg[31:28] == '0)
                        begin
                            x_next = {x_reg[27:0], 4'd0};
                            e_next = e_reg - 5'd4;
                        end
                    end
                    4'd1:
                    begin
                        if (x_reg[31:30] == '0)
                        begin
                            x_next = {x_reg[29:0], 2'd0};
                            e_next = e_reg - 5'd2;
                        end
                    end
                    default:
                    begin
                        if (!x_reg[31])
                        begin
                            x_next = {x_reg[30:0], 1'b0};
                            e_next = e_reg - 5'd1;
                        end
                    end
                endcase
                if (cnt_reg == '0)
                begin
                    cnt_next   = 4'd15;
                    state_next = ST_SQR;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_SQR:
            begin
                frac_next = {frac_reg[FRAC_W-2:0], sq_q31[32]};
                x_next    = sq_q31[32] ? sq_q31[32:1] : sq_q31[31:0];
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ----- src/pmdb_back.sv -----
// ----------------------------------------------------------------------------
// pmdb_back
// Per-channel sequencer: level in tenths of dB, target, display ballistics
// and the result register.
// ----------------------------------------------------------------------------
module pmdb_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  pmdb_pkg::pmdb_q_status_t                      q_status,
    input  logic [NUM_CHANNELS-1:0][pmdb_pkg::PEAK_W-1:0] head_data,
    output logic                                          pop,
    input  logic [pmdb_pkg::DECAY_W-1:0]                  decay_step,
    input  logic [pmdb_pkg::PEAK_W-1:0]                   noise_floor,
    output logic                                          log_start,
    output logic [pmdb_pkg::PEAK_W-1:0]                   log_peak,
    input  pmdb_pkg::pmdb_log_res_t                       log_res,
    output logic                                          result_valid,
    input  logic                                          result_stall,
    output logic [pmdb_pkg::CHAN_W-1:0]                   channel,
    output logic [pmdb_pkg::BAR_W-1:0]                    bar_level,
    output logic signed [pmdb_pkg::LEVEL_W-1:0]           level_tenths_db,
    output logic                                          last
);
    import pmdb_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_LOG     = 3'd2;
    localparam logic [2:0] S_SCALE   = 3'd3;
    localparam logic [2:0] S_TARGET  = 3'd4;
    localparam logic [2:0] S_DISPLAY = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               ch_reg, ch_next;
    logic [PEAK_W-1:0]           peaks_reg  [NUM_CHANNELS];
    logic [PEAK_W-1:0]           peaks_next [NUM_CHANNELS];
    logic [DISP_W-1:0]           disp_reg   [NUM_CHANNELS];
    logic [DISP_W-1:0]           disp_next  [NUM_CHANNELS];
    logic [42:0]                 prod_reg, prod_next;
    logic signed [LEVEL_W-1:0]   level_reg, level_next;
    logic [DISP_W-1:0]           target_reg, target_next;

    logic                        out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]           out_chan_reg, out_chan_next;
    logic [BAR_W-1:0]            out_bar_reg, out_bar_next;
    logic signed [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic                        out_last_reg, out_last_next;

    logic [LOG_W-1:0]            neg_d;
    logic [42:0]                 db_prod;
    logic [43:0]                 rounded;
    logic [11:0]                 mag;
    logic [11:0]                 neg_mag;
    logic [11:0]                 lvl_sum;
    logic [31:0]                 tgt_prod;
    logic [DISP_W-1:0]           disp_cur;
    logic [DISP_W:0]             disp_dec;
    logic [29:0]                 bar_prod;
    logic                        is_last_ch;
    logic                        out_free;

    assign log_peak   = peaks_reg[0];
    assign disp_cur   = disp_reg[ch_reg];
    assign is_last_ch = (ch_reg == CW'(NUM_CHANNELS - 1));
    assign out_free   = !out_valid_reg || !result_stall;

    // -d = 31.0 - log2(p), only used when the exponent is below 31
    assign neg_d    = {FULL_SCALE_EXP, {FRAC_W{1'b0}}} - {log_res.exp, log_res.frac};
    assign db_prod  = neg_d * DB_SCALE_Q16;
    assign rounded  = {1'b0, prod_reg} + 44'h0_8000_0000;
    assign mag      = rounded[43:32];
    assign neg_mag  = 12'd0 - mag;
    assign lvl_sum  = {level_reg[LEVEL_W-1], level_reg} + LEVEL_SPAN;
    assign tgt_prod = lvl_sum[9:0] * TARGET_MUL;
    assign disp_dec = {1'b0, disp_cur} - {1'b0, decay_step};
    assign bar_prod = disp_cur * BAR_MUL;

    assign result_valid    = out_valid_reg;
    assign channel         = out_chan_reg;
    assign bar_level       = out_bar_reg;
    assign level_tenths_db = out_level_reg;
    assign last            = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        prod_next      = prod_reg;
        level_next     = level_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_chan_next  = out_chan_reg;
        out_bar_next   = out_bar_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        log_start      = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            peaks_next[i] = peaks_reg[i];
            disp_next[i]  = disp_reg[i];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop     = 1'b1;
                    ch_next = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        peaks_next[i] = head_data[i];
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((peaks_reg[0] < noise_floor) || (peaks_reg[0] == '0))
                begin
                    level_next = LEVEL_MIN;
                    state_next = S_TARGET;
                end
                else
                begin
                    log_start  = 1'b1;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                if (log_res.done)
                begin
                    if (log_res.exp == FULL_SCALE_EXP)
                    begin
                        // at or above full scale
                        level_next = '0;
                        state_next = S_TARGET;
                    end
                    else
                    begin
                        prod_next  = db_prod;
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                if (mag > LEVEL_SPAN)
                begin
                    level_next = LEVEL_MIN;
                end
                else
                begin
                    level_next = neg_mag[LEVEL_W-1:0];
                end
                state_next = S_TARGET;
            end
            S_TARGET:
            begin
                target_next = tgt_prod[30:17];
                state_next  = S_DISPLAY;
            end
            S_DISPLAY:
            begin
                if (target_reg >= disp_cur)
                begin
                    disp_next[ch_reg] = target_reg;
                end
                else if (disp_dec[DISP_W] || (disp_dec[DISP_W-1:0] < target_reg))
                begin
                    disp_next[ch_reg] = target_reg;
                end
                else
                begin
                    disp_next[ch_reg] = disp_dec[DISP_W-1:0];
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = CHAN_W'(ch_reg);
                    out_bar_next   = bar_prod[28:19];
                    out_level_next = level_reg;
                    out_last_next  = is_last_ch;
                    for (int i = 0; i < NUM_CHANNELS - 1; i++)
                    begin
                        peaks_next[i] = peaks_reg[i + 1];
                    end
                    peaks_next[NUM_CHANNELS - 1] = '0;
                    if (is_last_ch)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CW'(1);
                        state_next = S_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            peaks_reg[i] <= peaks_next[i];
        end
        prod_reg      <= prod_next;
        level_reg     <= level_next;
        target_reg    <= target_next;
        out_chan_reg  <= out_chan_next;
        out_bar_reg   <= out_bar_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                disp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                disp_reg[i] <= disp_next[i];
            end
        end
    end

endmodule

// ----- src/pmdb_checker.sv -----
// ----------------------------------------------------------------------------
// pmdb_checker
// Port-level checks on the peak meter result channel.
// ----------------------------------------------------------------------------
`include "peak_meter_db_ballistics_assert.svh"

module pmdb_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic [pmdb_pkg::CHAN_W-1:0]         channel,
    input logic [pmdb_pkg::BAR_W-1:0]          bar_level,
    input logic signed [pmdb_pkg::LEVEL_W-1:0] level_tenths_db,
    input logic                                last
);
    import pmdb_pkg::*;

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);

    // stalled transfer keeps its payload
    `PMDB_ASSERT_NXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(channel) && $stable(bar_level) && $stable(level_tenths_db) && $stable(last))

    `PMDB_ASSERT_IMP(a_level_range, clk, rst_n, result_valid, (level_tenths_db >= LEVEL_MIN) && (level_tenths_db <= 11'sd0))

    `PMDB_ASSERT_IMP(a_bar_range, clk, rst_n, result_valid, bar_level <= 10'd1000)

    // last only on the final channel of a tick
    `PMDB_ASSERT_IMP(a_last_chan, clk, rst_n, result_valid && last, channel == LAST_CHAN)

endmodule

bind peak_meter_db_ballistics pmdb_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_pmdb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .channel         (channel),
    .bar_level       (bar_level),
    .level_tenths_db (level_tenths_db),
    .last            (last)
);
